>>> design/pidci_pkg.sv
package pidci_pkg;

	localparam int FRAC_BITS_DEF = 8;

	localparam int SP_W       = 20;
	localparam int ERR_W      = SP_W + 1;
	localparam int DIFF_W     = ERR_W + 1;
	localparam int MAG_W      = ERR_W;
	localparam int GAIN_W     = 16;
	localparam int LIM_W      = 8;
	localparam int MS_W       = 16;
	localparam int DRV_W      = 9;
	localparam int PROD_W     = GAIN_W + MAG_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd12800;
	localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd26;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd128;
	localparam logic [GAIN_W-1:0] INTEG_TOL_RST  = 16'd64;
	localparam logic [GAIN_W-1:0] DERIV_BAND_RST = 16'd1280;
	localparam logic [LIM_W-1:0]  OUT_LIMIT_RST  = 8'd220;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN  = 3'd0,
		REG_INTEG_GAIN = 3'd1,
		REG_DERIV_GAIN = 3'd2,
		REG_INTEG_TOL  = 3'd3,
		REG_DERIV_BAND = 3'd4,
		REG_OUT_LIMIT  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] prop_gain;
		logic [GAIN_W-1:0] integ_gain;
		logic [GAIN_W-1:0] deriv_gain;
		logic [GAIN_W-1:0] integ_tol;
		logic [GAIN_W-1:0] deriv_band;
		logic [LIM_W-1:0]  output_limit;
	} cfg_t;

endpackage

>>> design/pidci_cfg.sv
module pidci_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pidci_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pidci_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output pidci_pkg::cfg_t                      cfg
);

	pidci_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain    <= pidci_pkg::PROP_GAIN_RST;
			cfg_q.integ_gain   <= pidci_pkg::INTEG_GAIN_RST;
			cfg_q.deriv_gain   <= pidci_pkg::DERIV_GAIN_RST;
			cfg_q.integ_tol    <= pidci_pkg::INTEG_TOL_RST;
			cfg_q.deriv_band   <= pidci_pkg::DERIV_BAND_RST;
			cfg_q.output_limit <= pidci_pkg::OUT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (pidci_pkg::cfg_idx_t'(cfg_index))
				pidci_pkg::REG_PROP_GAIN:  cfg_q.prop_gain  <= cfg_wdata;
				pidci_pkg::REG_INTEG_GAIN: cfg_q.integ_gain <= cfg_wdata;
				pidci_pkg::REG_DERIV_GAIN: cfg_q.deriv_gain <= cfg_wdata;
				pidci_pkg::REG_INTEG_TOL:  cfg_q.integ_tol  <= cfg_wdata;
				pidci_pkg::REG_DERIV_BAND: cfg_q.deriv_band <= cfg_wdata;
				pidci_pkg::REG_OUT_LIMIT:  cfg_q.output_limit <= cfg_wdata[pidci_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/pidci_mul.sv
module pidci_mul (
	input  logic                           clk,
	input  logic [pidci_pkg::GAIN_W-1:0]   a,
	input  logic [pidci_pkg::MAG_W-1:0]    b,
	output logic [pidci_pkg::PROD_W-1:0]   prod
);

	logic [pidci_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= pidci_pkg::PROD_W'(a) * pidci_pkg::PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

>>> design/pidci_div.sv
module pidci_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pidci_pkg::PROD_W-1:0]   dividend,
	input  logic [pidci_pkg::MS_W-1:0]     divisor,
	output logic                           done,
	output logic [pidci_pkg::PROD_W-1:0]   quotient
);

	localparam int DVD_W = pidci_pkg::PROD_W;
	localparam int DVS_W = pidci_pkg::MS_W;
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> design/pid_conditional_integral_controller_top.sv
// Flow: an accepted word passes S_PREP, S_MUL_P, S_MUL_I, S_MUL_D, S_DIV_LD,
// S_DIV_WAIT, S_SUM and S_OUT; S_DIV_WAIT is bypassed when the derivative is
// skipped (zero elapsed time or error above band). Words are taken only in S_IDLE;
// the serial divider dominates, the three products share one registered multiplier.
// Reset (arst_n low): gains, limits at defaults, integral, last error and last
// setpoint cleared, no result pending.
module pid_conditional_integral_controller_top #(
	parameter int FRAC_BITS = pidci_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [pidci_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pidci_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [pidci_pkg::SP_W-1:0]      setpoint,
	input  logic signed [pidci_pkg::SP_W-1:0]      reading,
	input  logic [pidci_pkg::MS_W-1:0]             elapsed_ms,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [pidci_pkg::DRV_W-1:0]     drive
);

	localparam int F      = FRAC_BITS;
	localparam int ERR_W  = pidci_pkg::ERR_W;
	localparam int DIFF_W = pidci_pkg::DIFF_W;
	localparam int MAG_W  = pidci_pkg::MAG_W;
	localparam int PROD_W = pidci_pkg::PROD_W;
	localparam int DRV_W  = pidci_pkg::DRV_W;
	localparam int INT_W  = F + 10;
	localparam int STEP_W = PROD_W - F;
	localparam int ACC_W  = ((INT_W > STEP_W + 1) ? INT_W : STEP_W + 1) + 1;
	localparam int SUM_W  = ((PROD_W + 1 > INT_W + F) ? PROD_W + 1 : INT_W + F) + 2;

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_PREP     = 9'b000000010,
		S_MUL_P    = 9'b000000100,
		S_MUL_I    = 9'b000001000,
		S_MUL_D    = 9'b000010000,
		S_DIV_LD   = 9'b000100000,
		S_DIV_WAIT = 9'b001000000,
		S_SUM      = 9'b010000000,
		S_OUT      = 9'b100000000
	} state_t;

	pidci_pkg::cfg_t cfg;

	state_t                           state_q;
	logic                             out_valid_q;
	logic signed [DRV_W-1:0]          drive_q;
	logic signed [INT_W-1:0]          int_q;
	logic signed [ERR_W-1:0]          last_err_q;
	logic signed [pidci_pkg::SP_W-1:0] last_sp_q;

	logic signed [ERR_W-1:0]          err_q;
	logic [pidci_pkg::MS_W-1:0]       ms_q;
	logic                             spchg_q;
	logic [MAG_W-1:0]                 emag_q;
	logic                             eneg_q;
	logic signed [DIFF_W-1:0]         diff_q;
	logic                             dskip_q;
	logic [MAG_W-1:0]                 dmag_q;
	logic                             dneg_q;
	logic                             icond_q;
	logic signed [PROD_W:0]           p_q;
	logic signed [ACC_W-1:0]          acc_q;
	logic signed [PROD_W:0]           d_q;
	logic signed [SUM_W-1:0]          sum_q;

	logic [pidci_pkg::GAIN_W-1:0]     mul_a;
	logic [MAG_W-1:0]                 mul_b;
	logic [PROD_W-1:0]                prod;
	logic                             div_start;
	logic                             div_done;
	logic [PROD_W-1:0]                quo;

	logic [MAG_W-1:0]                 lmag;
	logic signed [PROD_W:0]           prod_s;
	logic signed [PROD_W:0]           quo_s;
	logic [DIFF_W-1:0]                dmag_full;
	logic [STEP_W-1:0]                step_mag;
	logic signed [STEP_W:0]           step_s;
	logic signed [ACC_W-1:0]          lim_i_s;
	logic signed [INT_W-1:0]          int_nxt;
	logic signed [ERR_W-1:0]          band_s;
	logic signed [INT_W+F-1:0]        int_sh;
	logic signed [SUM_W-1:0]          lim_o_s;
	logic signed [SUM_W-1:0]          rnd;
	logic signed [DRV_W-1:0]          lim_drv;
	logic signed [DRV_W-1:0]          drive_nxt;

	pidci_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pidci_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	pidci_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (ms_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		unique case (state_q)
			S_MUL_I: begin
				mul_a = cfg.integ_gain;
				mul_b = emag_q;
			end
			S_MUL_D: begin
				mul_a = cfg.deriv_gain;
				mul_b = dmag_q;
			end
			default: begin
				mul_a = cfg.prop_gain;
				mul_b = emag_q;
			end
		endcase
	end

	assign div_start = (state_q == S_DIV_LD) && !dskip_q;

	assign lmag      = last_err_q[ERR_W-1] ? MAG_W'(-last_err_q) : MAG_W'(last_err_q);
	assign dmag_full = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);
	assign prod_s    = $signed({1'b0, prod});
	assign quo_s     = $signed({1'b0, quo});
	assign step_mag  = prod[PROD_W-1:F];
	assign step_s    = eneg_q ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
	assign band_s    = $signed(ERR_W'(cfg.deriv_band));
	assign lim_i_s   = ACC_W'($signed({1'b0, cfg.output_limit, {F{1'b0}}}));
	assign lim_o_s   = SUM_W'($signed({1'b0, cfg.output_limit, {(2 * F){1'b0}}}));
	assign int_sh    = $signed({int_q, {F{1'b0}}});
	assign lim_drv   = $signed({1'b0, cfg.output_limit});
	assign rnd       = sum_q + $signed({{(SUM_W - 2 * F){1'b0}}, {(2 * F){sum_q[SUM_W-1]}}});

	always_comb begin
		priority if (spchg_q) begin
			int_nxt = '0;
		end else if (acc_q > lim_i_s) begin
			int_nxt = INT_W'(lim_i_s);
		end else if (acc_q < -lim_i_s) begin
			int_nxt = INT_W'(-lim_i_s);
		end else begin
			int_nxt = INT_W'(acc_q);
		end
	end

	// clamp, then truncate toward zero
	always_comb begin
		priority if (sum_q > lim_o_s) begin
			drive_nxt = lim_drv;
		end else if (sum_q < -lim_o_s) begin
			drive_nxt = -lim_drv;
		end else begin
			drive_nxt = rnd[2*F+DRV_W-1:2*F];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			int_q       <= '0;
			last_err_q  <= '0;
			last_sp_q   <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					last_sp_q <= setpoint;
					state_q   <= S_PREP;
				end
				S_PREP:  state_q <= S_MUL_P;
				S_MUL_P: state_q <= S_MUL_I;
				S_MUL_I: state_q <= S_MUL_D;
				S_MUL_D: state_q <= S_DIV_LD;
				S_DIV_LD: begin
					int_q      <= int_nxt;
					last_err_q <= err_q;
					state_q    <= dskip_q ? S_SUM : S_DIV_WAIT;
				end
				S_DIV_WAIT: if (div_done) begin
					state_q <= S_SUM;
				end
				S_SUM: state_q <= S_OUT;
				S_OUT: if (!out_valid_q || out_ready) begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				err_q   <= ERR_W'(setpoint) - ERR_W'(reading);
				ms_q    <= elapsed_ms;
				spchg_q <= setpoint != last_sp_q;
			end
			S_PREP: begin
				emag_q  <= err_q[ERR_W-1] ? MAG_W'(-err_q) : MAG_W'(err_q);
				eneg_q  <= err_q[ERR_W-1];
				diff_q  <= DIFF_W'(err_q) - DIFF_W'(last_err_q);
				dskip_q <= (err_q > band_s) || (ms_q == '0);
			end
			S_MUL_P: begin
				dmag_q  <= dmag_full[MAG_W-1:0];
				dneg_q  <= diff_q[DIFF_W-1];
				icond_q <= (emag_q > lmag) || (emag_q > MAG_W'(cfg.integ_tol));
			end
			S_MUL_I: p_q <= eneg_q ? -prod_s : prod_s;
			S_MUL_D: acc_q <= icond_q ? ACC_W'(int_q) + ACC_W'(step_s) : ACC_W'(int_q);
			S_DIV_LD: if (dskip_q) begin
				d_q <= '0;
			end
			S_DIV_WAIT: if (div_done) begin
				d_q <= dneg_q ? -quo_s : quo_s;
			end
			S_SUM: sum_q <= SUM_W'(p_q) + SUM_W'(int_sh) + SUM_W'(d_q);
			S_OUT: if (!out_valid_q || out_ready) begin
				drive_q <= drive_nxt;
			end
			default: ;
		endcase
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;

endmodule

>>> tb/pid_conditional_integral_controller_top_test.sv
`timescale 1ns / 100ps

module pid_conditional_integral_controller_top_test;
	import pidci_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 60;
	localparam int CHUNK_ITEMS  = 50;
	localparam int STALL_CYCLES = 600;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	localparam logic signed [SP_W-1:0] SP_MAX = {1'b0, {(SP_W-1){1'b1}}};
	localparam logic signed [SP_W-1:0] SP_MIN = {1'b1, {(SP_W-1){1'b0}}};

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_wdata;
	logic                      in_valid;
	logic                      in_ready;
	logic signed [SP_W-1:0]    setpoint;
	logic signed [SP_W-1:0]    reading;
	logic [MS_W-1:0]           elapsed_ms;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [DRV_W-1:0]   drive;

	pid_conditional_integral_controller_top DUT (.*);

	always #2 clk = ~clk;

	// controller shadow: registers and loop state
	cfg_t ctl = '{PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST,
		INTEG_TOL_RST, DERIV_BAND_RST, OUT_LIMIT_RST};
	longint err_prev  = 0;
	longint integ_acc = 0;
	longint sp_prev   = 0;

	logic signed [DRV_W-1:0] drive_q[$];
	logic signed [DRV_W-1:0] exp_drive;

	int snd_idle_pct  = 23;
	int rcv_idle_pct  = 49;
	int hold_cycles   = 0;
	int errors        = 0;
	int words_checked = 0;
	int samples_sent  = 0;
	int reg_writes    = 0;
	int cycles        = 0;

	function automatic longint trunc_shift(longint v, int s);
		return (v < 0) ? -((-v) >>> s) : (v >>> s);
	endfunction

	function automatic longint clamp_sym(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic longint magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int rand_between(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic logic signed [DRV_W-1:0] predict_drive(
		logic signed [SP_W-1:0] sp, logic signed [SP_W-1:0] rd, logic [MS_W-1:0] ms);
		longint sp_l, err, lim_i, lim_o, p_term, d_term, sum;
		sp_l   = sp;
		err    = sp_l - longint'(rd);
		lim_i  = longint'(ctl.output_limit) << FRAC_BITS_DEF;
		lim_o  = longint'(ctl.output_limit) << (2 * FRAC_BITS_DEF);
		p_term = longint'(ctl.prop_gain) * err;
		if (magnitude(err) > magnitude(err_prev) || magnitude(err) > longint'(ctl.integ_tol))
			integ_acc += trunc_shift(longint'(ctl.integ_gain) * err, FRAC_BITS_DEF);
		if (sp_l != sp_prev)
			integ_acc = 0;
		integ_acc = clamp_sym(integ_acc, lim_i);
		if (err > longint'(ctl.deriv_band) || ms == '0)
			d_term = 0;
		else
			d_term = (longint'(ctl.deriv_gain) * (err - err_prev)) / longint'(ms);
		sum = clamp_sym(p_term + (integ_acc <<< FRAC_BITS_DEF) + d_term, lim_o);
		err_prev = err;
		sp_prev  = sp_l;
		return DRV_W'(trunc_shift(sum, 2 * FRAC_BITS_DEF));
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PROP_GAIN:  ctl.prop_gain    = val;
			REG_INTEG_GAIN: ctl.integ_gain   = val;
			REG_DERIV_GAIN: ctl.deriv_gain   = val;
			REG_INTEG_TOL:  ctl.integ_tol    = val;
			REG_DERIV_BAND: ctl.deriv_band   = val;
			REG_OUT_LIMIT:  ctl.output_limit = val[LIM_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic load_config(input logic [15:0] pg, input logic [15:0] ig,
		input logic [15:0] dg, input logic [15:0] tol, input logic [15:0] band,
		input logic [15:0] lim);
		write_reg(REG_PROP_GAIN, pg);
		write_reg(REG_INTEG_GAIN, ig);
		write_reg(REG_DERIV_GAIN, dg);
		write_reg(REG_INTEG_TOL, tol);
		write_reg(REG_DERIV_BAND, band);
		write_reg(REG_OUT_LIMIT, lim);
	endtask

	task automatic send_sample(input int sp_v, input int rd_v, input int ms_v);
		@(negedge clk);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		setpoint   <= SP_W'(sp_v);
		reading    <= SP_W'(rd_v);
		elapsed_ms <= MS_W'(ms_v);
		do
			@(posedge clk);
		while (!in_ready);
		drive_q.push_back(predict_drive(setpoint, reading, elapsed_ms));
		samples_sent++;
	endtask

	// let every pending drive word come back before touching registers
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (drive_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles--;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (drive_q.size() == 0) begin
				$error("drive: word with nothing expected, actual %0d", drive);
				errors++;
			end else begin
				exp_drive = drive_q.pop_front();
				if (drive !== exp_drive) begin
					$error("drive mismatch: expected %0d, actual %0d", exp_drive, drive);
					errors++;
				end
				words_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic test_reset_defaults();
		send_sample(0, 0, 0);
		send_sample(2560, 2304, 10);
		send_sample(2560, 2560, 10);
		drain();
	endtask

	task automatic test_field_extremes();
		send_sample(SP_MAX, SP_MIN, 65535);
		send_sample(SP_MIN, SP_MAX, 1);
		send_sample(SP_MAX, SP_MAX, 0);
		send_sample(SP_MIN, SP_MIN, 65535);
		drain();
	endtask

	task automatic test_gain_extremes();
		load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_sample(SP_MAX, SP_MIN, 1);
		send_sample(-256, 0, 1);
		send_sample(0, -256, 1);
		drain();
		load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd255);
		send_sample(1000, 200, 3);
		send_sample(1000, 1800, 3);
		drain();
	endtask

	task automatic test_special_cases();
		load_config(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, INTEG_TOL_RST,
			DERIV_BAND_RST, 16'(OUT_LIMIT_RST));
		send_sample(2560, 2500, 0);     // no elapsed time, derivative skipped
		send_sample(2560, 0, 5);        // error above band
		send_sample(3000, 2900, 5);     // new setpoint clears integral
		send_sample(3000, 2990, 5);     // shrinking error inside tolerance
		send_sample(3000, 2995, 5);
		drain();
		write_reg(REG_SPARE_A, 16'h0000);
		write_reg(REG_SPARE_B, 16'hFFFF);
		send_sample(3000, 2800, 7);
		drain();
		write_reg(REG_OUT_LIMIT, 16'h0000);
		send_sample(3000, 100, 7);
		send_sample(-3000, 100, 7);
		drain();
	endtask

	task automatic test_output_stall();
		hold_cycles = STALL_CYCLES;
		repeat (12) send_sample(rand_between(-4000, 4000), rand_between(-4000, 4000),
			rand_between(0, 50));
		drain();
	endtask

	task automatic test_random_traffic(input int n_items, input int snd_pct, input int rcv_pct);
		int sent, chunk, chunk_end, run_len, sp_v, off;
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		sent  = 0;
		chunk = 0;
		while (sent < n_items) begin
			drain();
			case (chunk % 5)
				0: load_config(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, INTEG_TOL_RST,
					DERIV_BAND_RST, 16'(OUT_LIMIT_RST));
				1: load_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom));
				2: load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: load_config(16'(rand_between(0, 4096)), 16'(rand_between(0, 512)),
					16'(rand_between(0, 512)), 16'(rand_between(0, 1024)),
					16'(rand_between(0, 4096)), 16'(rand_between(1, 255)));
				default: load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
					16'(rand_between(1, 255)));
			endcase
			chunk++;
			chunk_end = sent + CHUNK_ITEMS;
			while (sent < chunk_end && sent < n_items) begin
				if ($urandom_range(99) < 75) begin
					// reading settles toward a held setpoint
					run_len = rand_between(3, 20);
					sp_v    = rand_between(-30000, 30000);
					off     = rand_between(-3000, 3000);
					repeat (run_len) begin
						send_sample(sp_v, sp_v - off,
							($urandom_range(19) == 0) ? 0 : rand_between(1, 200));
						off = off * 3 / 4 + rand_between(-24, 24);
						sent++;
					end
				end else begin
					send_sample(rand_between(SP_MIN, SP_MAX), rand_between(SP_MIN, SP_MAX),
						rand_between(0, 65535));
					sent++;
				end
			end
		end
		drain();
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_wdata  = '0;
		in_valid   = 1'b0;
		setpoint   = '0;
		reading    = '0;
		elapsed_ms = '0;
		out_ready  = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_field_extremes();
		test_gain_extremes();
		test_special_cases();
		test_random_traffic(500, 23, 49);
		test_random_traffic(500, 49, 23);
		test_output_stall();
		test_random_traffic(500, 0, 0);

		$display("Covered %0d control samples and %0d register writes; %0d drive words checked",
			samples_sent, reg_writes, words_checked);
		$display("Phases: directed corners, settling runs and noise under three idle profiles, output stall");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
